// File: rtl/arp_pkg.sv
// Package for the AT response parser: character codes, parse positions and
// the parser state record. Used by arp_next_state and at_response_parser_unit.
// No dependencies.
package arp_pkg;

    // Characters recognised in a modem reply.
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_R    = 8'h52;

    // Reported status codes.
    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_FMT   = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    // Parse positions within a reply.
    typedef enum logic [4:0] {
        P_START   = 5'd0,
        P_LF1     = 5'd1,
        P_FIRST   = 5'd2,
        P_INFO    = 5'd3,
        P_INFOTXT = 5'd4,
        P_INFOLF  = 5'd5,
        P_AFTER   = 5'd6,
        P_BLANKLF = 5'd7,
        P_FINAL   = 5'd8,
        P_O       = 5'd9,
        P_OKCR    = 5'd10,
        P_E       = 5'd11,
        P_ER      = 5'd12,
        P_ERR     = 5'd13,
        P_ERRO    = 5'd14,
        P_ERRCR   = 5'd15,
        P_ENDLF   = 5'd16,
        P_DONE    = 5'd17
    } pos_t;

    // Complete parser state carried from byte to byte.
    typedef struct packed {
        pos_t       pos;
        logic [1:0] status;
        logic [1:0] pending;
    } arp_state_t;

endpackage

// File: rtl/arp_next_state.sv
// Next-state logic of the AT response parser: one byte against the current state.
// Depends on arp_pkg.
module arp_next_state
    import arp_pkg::*;
(
    input  arp_state_t cur_state,
    input  logic [7:0] byte_in,
    output arp_state_t nxt_state
);

    // Decode of the byte against each recognised character.
    logic is_cr;
    logic is_lf;
    logic is_plus;
    logic is_o;
    logic is_e;
    logic is_k;
    logic is_r;

    assign is_cr   = (byte_in == CH_CR);
    assign is_lf   = (byte_in == CH_LF);
    assign is_plus = (byte_in == CH_PLUS);
    assign is_o    = (byte_in == CH_O);
    assign is_e    = (byte_in == CH_E);
    assign is_k    = (byte_in == CH_K);
    assign is_r    = (byte_in == CH_R);

    // Position transitions. An unexpected byte flags a format error and ends
    // the reply, except at the closing LF where the position is kept.
    always_comb begin
        nxt_state = cur_state;
        case (cur_state.pos)
            P_START: begin
                if (is_cr) nxt_state.pos = P_LF1;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_LF1: begin
                if (is_lf) nxt_state.pos = P_FIRST;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_FIRST: begin
                if (is_plus)   nxt_state.pos = P_INFO;
                else if (is_o) nxt_state.pos = P_O;
                else if (is_e) nxt_state.pos = P_E;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_INFO: begin
                // Repeated '+' characters are skipped.
                if (!is_plus) nxt_state.pos = P_INFOTXT;
            end
            P_INFOTXT: begin
                nxt_state.pos = is_cr ? P_INFOLF : P_INFO;
            end
            P_INFOLF: begin
                if (is_lf) nxt_state.pos = P_AFTER;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_AFTER: begin
                if (is_o)         nxt_state.pos = P_O;
                else if (is_e)    nxt_state.pos = P_E;
                else if (is_plus) nxt_state.pos = P_INFO;
                else if (is_cr)   nxt_state.pos = P_BLANKLF;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_BLANKLF: begin
                if (is_lf) nxt_state.pos = P_FINAL;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_FINAL: begin
                if (is_o)      nxt_state.pos = P_O;
                else if (is_e) nxt_state.pos = P_E;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_O: begin
                if (is_k) begin
                    nxt_state.pos     = P_OKCR;
                    nxt_state.pending = ST_OK;
                end else begin
                    nxt_state.pos = P_DONE; nxt_state.status = ST_FMT;
                end
            end
            P_OKCR: begin
                if (is_cr) nxt_state.pos = P_ENDLF;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_E: begin
                if (is_r) nxt_state.pos = P_ER;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_ER: begin
                if (is_r) nxt_state.pos = P_ERR;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_ERR: begin
                if (is_o) nxt_state.pos = P_ERRO;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_ERRO: begin
                if (is_r) begin
                    nxt_state.pos     = P_ERRCR;
                    nxt_state.pending = ST_ERROR;
                end else begin
                    nxt_state.pos = P_DONE; nxt_state.status = ST_FMT;
                end
            end
            P_ERRCR: begin
                if (is_cr) nxt_state.pos = P_ENDLF;
                else begin nxt_state.pos = P_DONE; nxt_state.status = ST_FMT; end
            end
            P_ENDLF: begin
                // A bad byte flags an error but a later LF still closes the reply.
                if (is_lf) begin
                    nxt_state.pos    = P_DONE;
                    nxt_state.status = cur_state.pending;
                end else begin
                    nxt_state.status = ST_FMT;
                end
            end
            P_DONE: begin
                // A CR after a clean reply restarts; anything else keeps the status.
                if ((cur_state.status != ST_FMT) && is_cr) begin
                    nxt_state.pos     = P_LF1;
                    nxt_state.status  = ST_BUSY;
                    nxt_state.pending = ST_BUSY;
                end else begin
                    nxt_state.pos = P_START;
                end
            end
            default: begin
                nxt_state = cur_state;
            end
        endcase
    end

endmodule

// File: rtl/at_response_parser_unit.sv
// AT response parser top level: one reply byte per transfer, one status per byte.
// The status of a byte is registered and presented on the cycle after its transfer.
// One byte every clock as long as each status is taken as soon as it is presented.
// While a status waits, the next byte is taken only in the cycle that status is taken.
// Reset (aresetn, synchronous, active low): position to start, status and
// pending code to zero, output register empty.
module at_response_parser_unit
    import arp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status
);

    arp_state_t state_reg;
    arp_state_t state_next;
    logic       m_valid_reg;
    logic [1:0] m_status_reg;
    logic       in_xfer;

    // A byte is taken whenever the output register is free or being emptied.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    arp_next_state u_next (
        .cur_state (state_reg),
        .byte_in   (s_byte_in),
        .nxt_state (state_next)
    );

    // Parser state and the output register holding the status of the latest byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.pos     <= P_START;
            state_reg.status  <= ST_BUSY;
            state_reg.pending <= ST_BUSY;
            m_valid_reg       <= 1'b0;
            m_status_reg      <= ST_BUSY;
        end else if (in_xfer) begin
            state_reg    <= state_next;
            m_valid_reg  <= 1'b1;
            m_status_reg <= state_next.status;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

`ifndef SYNTHESIS
    // Every accepted byte produces a status on the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_valid)
        else $error("no status after an input transfer");

    // The presented status always matches the parser's status register.
    a_status_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == state_reg.status))
        else $error("output status differs from parser state");

    // The pending code is never the format-error code.
    a_pending_code: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pending != ST_FMT)
        else $error("pending code holds a format error");

    // Awaiting the closing LF implies a final code has been recognised.
    a_endlf_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.pos == P_ENDLF) |->
            ((state_reg.pending == ST_OK) || (state_reg.pending == ST_ERROR)))
        else $error("closing LF awaited without a final code");
`endif

endmodule

// File: tb/arp_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the AT response parser testbench: a bit-exact predictor of the
// reply status and the queue of statuses still owed by the block.
// Depends on arp_pkg for the character codes, status codes and parse positions.
package arp_scoreboard_pkg;

    import arp_pkg::*;

    class reply_status_tracker;

        pos_t       pos;
        logic [1:0] status;
        logic [1:0] pending;
        logic [1:0] expected_status[$];
        int         mismatches;

        function new();
            pos        = P_START;
            status     = ST_BUSY;
            pending    = ST_BUSY;
            mismatches = 0;
        endfunction

        // Move on when the byte matches, otherwise flag a format error.
        function void advance_if(bit matched, pos_t nxt);
            if (matched) begin
                pos = nxt;
            end else begin
                status = ST_FMT;
                pos    = P_DONE;
            end
        endfunction

        // Update the parser state for one accepted byte and note the status it yields.
        function void take_byte(logic [7:0] c);
            case (pos)
                P_START:   advance_if(c == CH_CR, P_LF1);
                P_LF1:     advance_if(c == CH_LF, P_FIRST);
                P_FIRST: begin
                    if (c == CH_PLUS)   pos = P_INFO;
                    else if (c == CH_O) pos = P_O;
                    else if (c == CH_E) pos = P_E;
                    else                advance_if(1'b0, P_DONE);
                end
                // Repeated '+' characters are skipped before the text starts.
                P_INFO: begin
                    if (c != CH_PLUS) pos = P_INFOTXT;
                end
                P_INFOTXT: pos = (c == CH_CR) ? P_INFOLF : P_INFO;
                P_INFOLF:  advance_if(c == CH_LF, P_AFTER);
                P_AFTER: begin
                    if (c == CH_O)         pos = P_O;
                    else if (c == CH_E)    pos = P_E;
                    else if (c == CH_PLUS) pos = P_INFO;
                    else if (c == CH_CR)   pos = P_BLANKLF;
                    else                   advance_if(1'b0, P_DONE);
                end
                P_BLANKLF: advance_if(c == CH_LF, P_FINAL);
                P_FINAL: begin
                    if (c == CH_O)      pos = P_O;
                    else if (c == CH_E) pos = P_E;
                    else                advance_if(1'b0, P_DONE);
                end
                P_O: begin
                    if (c == CH_K) pending = ST_OK;
                    advance_if(c == CH_K, P_OKCR);
                end
                P_OKCR:    advance_if(c == CH_CR, P_ENDLF);
                P_E:       advance_if(c == CH_R, P_ER);
                P_ER:      advance_if(c == CH_R, P_ERR);
                P_ERR:     advance_if(c == CH_O, P_ERRO);
                P_ERRO: begin
                    if (c == CH_R) pending = ST_ERROR;
                    advance_if(c == CH_R, P_ERRCR);
                end
                P_ERRCR:   advance_if(c == CH_CR, P_ENDLF);
                // A bad byte here flags the error but keeps waiting for the LF.
                P_ENDLF: begin
                    if (c == CH_LF) begin
                        status = pending;
                        pos    = P_DONE;
                    end else begin
                        status = ST_FMT;
                    end
                end
                // A clean reply followed by CR restarts; anything else keeps the status.
                P_DONE: begin
                    if (status != ST_FMT && c == CH_CR) begin
                        pos     = P_LF1;
                        status  = ST_BUSY;
                        pending = ST_BUSY;
                    end else begin
                        pos = P_START;
                    end
                end
                default: ;
            endcase
            expected_status.push_back(status);
        endfunction

        // Compare one status transfer with the oldest outstanding prediction.
        function void check_status(logic [1:0] got);
            logic [1:0] want;
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("status %0d transferred with none outstanding", got);
            end else begin
                want = expected_status.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("status mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction

    endclass

endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for at_response_parser_unit: drives reply bytes with random
// idling and a long receiver hold-off, and checks every status transfer.
// Depends on arp_pkg and arp_scoreboard_pkg.
module tb;

    import arp_pkg::*;
    import arp_scoreboard_pkg::*;

    localparam int NUM_ITEMS   = 1900;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 250;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte_in = 8'd0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [1:0] m_status;

    reply_status_tracker sb     = new();
    reply_status_tracker shadow = new();
    logic [7:0]          stim_q[$];
    int                  offered = 0;

    at_response_parser_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_byte_in(s_byte_in),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status)
    );

    always #10 aclk = ~aclk;

    // Queue a stimulus byte and track where the parser will stand after it.
    task automatic push_byte(logic [7:0] b);
        stim_q.push_back(b);
        shadow.take_byte(b);
        void'(shadow.expected_status.pop_front());
    endtask

    // Offer every queued byte, holding each one until its transfer completes.
    task automatic send_stream();
        int  accepted;
        bit  steady;
        accepted = 0;
        while (accepted < stim_q.size()) begin
            @(posedge aclk);
            if (s_valid && s_ready) begin
                sb.take_byte(s_byte_in);
                accepted++;
            end
            if (!s_valid || s_ready) begin
                steady = (offered >= 1100 && offered < 1400);
                if (offered < stim_q.size() && (steady || $urandom_range(0, 99) >= 35)) begin
                    s_valid   <= 1'b1;
                    s_byte_in <= stim_q[offered];
                    offered++;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    endtask

    // Result side: take status transfers, idle at random, and hold off once for a long stretch.
    initial begin
        int hold_left;
        bit held_once;
        int taken;
        hold_left = 0;
        held_once = 0;
        taken     = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready) begin
                sb.check_status(m_status);
                taken++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_once && taken >= 700) begin
                held_once = 1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (taken >= 1100 && taken < 1400) || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge aclk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        logic [7:0] directed[27];
        logic [7:0] reply[$];
        logic [7:0] b;
        int         n_lines;
        int         text_len;
        bit         free_text;

        // Info line with repeated '+' and a high byte, blank line, a bad byte where
        // the closing LF belongs, a status carried past a stray byte, an ERROR reply,
        // and a format error followed by CR at the done position.
        directed = '{CH_CR, CH_LF, CH_PLUS, CH_PLUS, 8'h80, CH_CR, CH_LF, CH_CR, CH_LF,
                     CH_O, CH_K, CH_CR, 8'hFF, CH_LF, 8'h00,
                     CH_CR, CH_LF, CH_E, CH_R, CH_R, CH_O, CH_R, CH_CR, CH_LF,
                     8'hFF, 8'hFF, CH_CR};
        foreach (directed[i])
            push_byte(directed[i]);

        // Random replies, mostly well formed, with corrupted replies and noise bursts.
        while (stim_q.size() < NUM_ITEMS) begin
            // Steer the parser back to the start or a clean done position first.
            while (!(shadow.pos == P_START ||
                     (shadow.pos == P_DONE && shadow.status != ST_FMT))) begin
                case (shadow.pos)
                    P_DONE:    push_byte(8'h00);
                    P_ENDLF:   push_byte(CH_LF);
                    P_INFO:    push_byte(8'h01);
                    P_INFOTXT: push_byte(CH_CR);
                    default:   push_byte(8'hFF);
                endcase
            end
            if ($urandom_range(0, 99) < 20) begin
                repeat ($urandom_range(1, 5))
                    push_byte(8'($urandom_range(0, 255)));
            end else begin
                reply.delete();
                reply.push_back(CH_CR);
                reply.push_back(CH_LF);
                n_lines = $urandom_range(0, 3);
                repeat (n_lines) begin
                    repeat ($urandom_range(1, 2))
                        reply.push_back(CH_PLUS);
                    // An odd text length ends the line in the text position.
                    free_text = ($urandom_range(0, 9) == 0);
                    text_len  = 2 * $urandom_range(0, 3) + 1;
                    repeat (text_len) begin
                        b = 8'($urandom_range(0, 255));
                        while (!free_text && (b == CH_PLUS || b == CH_CR))
                            b = 8'($urandom_range(0, 255));
                        reply.push_back(b);
                    end
                    reply.push_back(CH_CR);
                    reply.push_back(CH_LF);
                end
                if (n_lines > 0 && $urandom_range(0, 99) < 30) begin
                    reply.push_back(CH_CR);
                    reply.push_back(CH_LF);
                end
                if ($urandom_range(0, 1) == 0) begin
                    reply.push_back(CH_O);
                    reply.push_back(CH_K);
                end else begin
                    reply.push_back(CH_E);
                    reply.push_back(CH_R);
                    reply.push_back(CH_R);
                    reply.push_back(CH_O);
                    reply.push_back(CH_R);
                end
                reply.push_back(CH_CR);
                reply.push_back(CH_LF);
                if ($urandom_range(0, 99) < 10)
                    reply[$urandom_range(0, reply.size() - 1)] = 8'($urandom_range(0, 255));
                foreach (reply[i])
                    push_byte(reply[i]);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_stream();

        // Drain the outstanding statuses, then keep watching for stray statuses before the verdict.
        while (sb.expected_status.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (sb.mismatches == 0 && sb.expected_status.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
